### src/assert_macros.svh
// Assertion macros shared by the encoder RTL.
// Simulation builds get concurrent assertions; synthesis builds get nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define FSB_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

`define FSB_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define FSB_ASSERT(label, clk, rst_n, prop)

`define FSB_NEVER(label, clk, rst_n, cond)

`endif

`endif

### src/fsb64_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Filename-safe base64 package
// Shared types, constants and the alphabet lookup for the encoder.
// ----------------------------------------------------------------------------
package fsb64_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam logic [1:0] HELD_MAX = 2'd2;
    localparam logic [1:0] LAST_PHASE = 2'd3;

    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic       fin;
    } t_group;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic [7:0] f_char(input logic [5:0] idx);
        logic [7:0] wide;
        wide = {2'b00, idx};
        case (idx) inside
            [6'd0:6'd1]:   return 8'h2D + wide;
            [6'd2:6'd11]:  return 8'h30 + wide - 8'd2;
            [6'd12:6'd37]: return 8'h41 + wide - 8'd12;
            default:       return 8'h61 + wide - 8'd38;
        endcase
    endfunction

    function automatic logic [5:0] f_sextet(input t_group g, input logic [1:0] phase);
        case (phase)
            2'd0:    return g.b0[7:2];
            2'd1:    return {g.b0[1:0], g.b1[7:4]};
            2'd2:    return {g.b1[3:0], g.b2[7:6]};
            default: return g.b2[5:0];
        endcase
    endfunction

endpackage

### src/fsb64_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder front end
// Accepts bytes, holds up to two and closes groups of up to three bytes.
// ----------------------------------------------------------------------------
module fsb64_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [7:0]            i_byte,
    input  logic                  i_last,
    output logic                  o_ready,
    input  fsb64_pkg::t_q_status  i_q,
    output logic                  o_push,
    output fsb64_pkg::t_group     o_group,
    output logic [1:0]            o_held
);
    import fsb64_pkg::*;

    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic [7:0] r_b0;
    logic [7:0] r_b1;
    logic [1:0] w_cnt_sat;
    logic       w_acc;
    logic       w_close;

    assign o_ready   = !i_q.full;
    assign w_acc     = i_valid && o_ready;
    assign w_cnt_sat = (r_cnt > HELD_MAX) ? HELD_MAX : r_cnt;
    assign w_close   = i_last || (w_cnt_sat == HELD_MAX);
    assign o_push    = w_acc && w_close;
    assign o_held    = r_cnt;

    always_comb begin
        case (w_cnt_sat)
            2'd0:    o_group = '{b0: i_byte, b1: 8'd0, b2: 8'd0, fin: i_last};
            2'd1:    o_group = '{b0: r_b0, b1: i_byte, b2: 8'd0, fin: i_last};
            default: o_group = '{b0: r_b0, b1: r_b1, b2: i_byte, fin: i_last};
        endcase
        n_cnt = r_cnt;
        if (w_acc) begin
            n_cnt = w_close ? 2'd0 : w_cnt_sat + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && !w_close) begin
            if (w_cnt_sat == 2'd0) begin
                r_b0 <= i_byte;
            end else begin
                r_b1 <= i_byte;
            end
        end
    end

endmodule

### src/fsb64_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Group queue
// Short FIFO of closed byte groups between the front and back ends.
// ----------------------------------------------------------------------------
module fsb64_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  fsb64_pkg::t_group     i_group,
    input  logic                  i_pop,
    output fsb64_pkg::t_group     o_group,
    output fsb64_pkg::t_q_status  o_status
);
    import fsb64_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [PTR_W:0]   CNT_FULL = (PTR_W + 1)'(QUEUE_DEPTH);

    t_group           r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [PTR_W:0]   r_cnt;

    assign o_group        = r_mem[r_rd];
    assign o_status.full  = (r_cnt == CNT_FULL);
    assign o_status.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_group;
        end
    end

endmodule

### src/fsb64_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder back end
// Splits one group into four sextets and sends one character per transaction.
// ----------------------------------------------------------------------------
module fsb64_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  fsb64_pkg::t_q_status  i_q,
    input  fsb64_pkg::t_group     i_group,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [7:0]            o_data,
    output logic                  o_last
);
    import fsb64_pkg::*;

    logic       r_busy;
    logic [1:0] r_phase;
    t_group     r_grp;
    logic       w_done;
    logic       w_load;

    assign o_valid = r_busy;
    assign o_data  = f_char(f_sextet(r_grp, r_phase));
    assign o_last  = r_grp.fin && (r_phase == LAST_PHASE);
    assign w_done  = r_busy && i_ready && (r_phase == LAST_PHASE);
    assign w_load  = !i_q.empty && (!r_busy || w_done);
    assign o_pop   = w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= 2'd0;
        end else if (w_load) begin
            r_busy  <= 1'b1;
            r_phase <= 2'd0;
        end else if (w_done) begin
            r_busy  <= 1'b0;
            r_phase <= 2'd0;
        end else if (r_busy && i_ready) begin
            r_phase <= r_phase + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_grp <= i_group;
        end
    end

endmodule

### src/filename_safe_base64_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Filename-safe base64 encoder
// Unpadded base64 over the alphabet "-.0-9A-Za-z", one byte in, one char out.
// ----------------------------------------------------------------------------
// Each input transaction carries one byte; tlast marks the last byte of a
// stream. Every third byte, or a byte with tlast, closes a group (missing
// bytes are zero) and yields four characters, the fourth carrying tlast when
// the group was closed by a final byte. No '=' padding is ever produced. The
// input side takes one byte per cycle while the two-entry group queue has
// room; the output side sends one character per cycle while a group is
// loaded and the receiver is ready, so the single-character output port
// sets the sustained rate. A closed group is written into the queue and then
// loaded into the back end's group register before its first char is sent.
module filename_safe_base64_encoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] data_byte
    input  logic       i_s_axis_tlast,   // final_byte
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_char
    output logic       o_m_axis_tlast    // final_char
);
    import fsb64_pkg::*;

`include "assert_macros.svh"

    t_group    w_front_group;
    t_group    w_head_group;
    t_q_status w_q;
    logic      w_push;
    logic      w_pop;
    logic [1:0] w_held;
    logic      w_in_last;

    assign w_in_last = i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast;

    fsb64_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .i_byte  (i_s_axis_tdata),
        .i_last  (i_s_axis_tlast),
        .o_ready (o_s_axis_tready),
        .i_q     (w_q),
        .o_push  (w_push),
        .o_group (w_front_group),
        .o_held  (w_held)
    );

    fsb64_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_group  (w_front_group),
        .i_pop    (w_pop),
        .o_group  (w_head_group),
        .o_status (w_q)
    );

    fsb64_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q     (w_q),
        .i_group (w_head_group),
        .o_pop   (w_pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata),
        .o_last  (o_m_axis_tlast)
    );

    `FSB_NEVER(a_no_push_full, i_clk, i_rst_n, w_push && w_q.full)
    `FSB_NEVER(a_no_pop_empty, i_clk, i_rst_n, w_pop && w_q.empty)
    `FSB_NEVER(a_held_bound, i_clk, i_rst_n, w_held == 2'd3)
    `FSB_ASSERT(a_last_clears, i_clk, i_rst_n, w_in_last |=> (w_held == 2'd0))

endmodule

### verif/filename_safe_base64_encoder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Filename-safe base64 encoder testbench
// Streams raw bytes into the encoder and checks every character that comes out
// against characters predicted from the held bytes, the group closing rules
// and the unpadded alphabet. The run goes through phases with no idling, an
// idle sender, a stalling receiver and both at once.
// ----------------------------------------------------------------------------
module filename_safe_base64_encoder_test;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_char_item;

    class b64_char_scoreboard;
        string        symbols = {"-.0123456789ABCD", "EFGHIJKLMNOPQRST",
                                 "UVWXYZabcdefghij", "klmnopqrstuvwxyz"};
        logic [7:0]   held_first;
        logic [7:0]   held_second;
        logic [1:0]   held_count;
        t_char_item   expected_chars[$];
        int unsigned  fail_count;

        function new();
            held_first  = 8'h00;
            held_second = 8'h00;
            held_count  = 2'd0;
            fail_count  = 0;
        endfunction

        function void note_byte(input logic [7:0] b, input logic fin);
            logic [23:0] group_bits;
            logic [5:0]  sextet;
            t_char_item  item;
            if (held_count < 2'd2 && !fin) begin
                if (held_count == 2'd0) begin
                    held_first = b;
                end else begin
                    held_second = b;
                end
                held_count = held_count + 2'd1;
                return;
            end
            case (held_count)
                2'd0:    group_bits = {b, 16'h0000};
                2'd1:    group_bits = {held_first, b, 8'h00};
                default: group_bits = {held_first, held_second, b};
            endcase
            for (int k = 0; k < 4; k++) begin
                sextet    = group_bits[23 - 6 * k -: 6];
                item.ch   = symbols[sextet];
                item.last = (k == 3) && fin;
                expected_chars.push_back(item);
            end
            held_count = 2'd0;
        endfunction

        function void check_char(input logic [7:0] ch, input logic last);
            t_char_item want;
            if (expected_chars.size() == 0) begin
                $error("out_char: unexpected transaction, got 0x%02h", ch);
                fail_count++;
                return;
            end
            want = expected_chars.pop_front();
            if (ch !== want.ch) begin
                $error("out_char mismatch: expected 0x%02h, got 0x%02h", want.ch, ch);
                fail_count++;
            end
            if (last !== want.last) begin
                $error("final_char mismatch: expected %0b, got %0b", want.last, last);
                fail_count++;
            end
        endfunction

        function int chars_outstanding();
            return expected_chars.size();
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_s_axis_tvalid = 1'b0;
    logic       o_s_axis_tready;
    logic [7:0] i_s_axis_tdata = 8'h00;    // [7:0] data_byte
    logic       i_s_axis_tlast = 1'b0;     // final_byte
    logic       o_m_axis_tvalid;
    logic       i_m_axis_tready = 1'b0;
    logic [7:0] o_m_axis_tdata;            // [7:0] out_char
    logic       o_m_axis_tlast;            // final_char

    int unsigned        send_idle_pct = 0;
    int unsigned        recv_stall_pct = 0;
    b64_char_scoreboard char_board = new();

    filename_safe_base64_encoder u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tlast (i_s_axis_tlast),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tlast (o_m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            char_board.check_char(o_m_axis_tdata, o_m_axis_tlast);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tlast  <= fin;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        char_board.note_byte(b, fin);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_random_streams(input int n_bytes);
        int sent;
        int len;
        sent = 0;
        while (sent < n_bytes) begin
            len = $urandom_range(1, 9);
            for (int i = 0; i < len; i++) begin
                send_byte(pick_byte(), i == len - 1);
                sent++;
            end
        end
        i_s_axis_tvalid <= 1'b0;
    endtask

    task automatic send_directed();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFC, 1'b0);
        send_byte(8'h0F, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b1);
        i_s_axis_tvalid <= 1'b0;
    endtask

    initial begin
        int unsigned idle_pcts[4];
        int unsigned stall_pcts[4];
        idle_pcts  = '{0, 76, 0, 36};
        stall_pcts = '{0, 0, 76, 36};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct  = idle_pcts[phase];
            recv_stall_pct = stall_pcts[phase];
            if (phase == 0) begin
                send_directed();
            end
            send_random_streams(25);
            while (char_board.chars_outstanding() != 0) @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
        if (char_board.fail_count == 0) begin
            $display("filename_safe_base64_encoder regression: pass");
        end else begin
            $display("filename_safe_base64_encoder regression: fail");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("filename_safe_base64_encoder regression: fail");
        $finish;
    end

endmodule

### filename_safe_base64_encoder.f
+incdir+src
src/fsb64_pkg.sv
src/fsb64_front.sv
src/fsb64_queue.sv
src/fsb64_back.sv
src/filename_safe_base64_encoder.sv
verif/filename_safe_base64_encoder_test.sv
